/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// No dependencies; clk and rst_n are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define RSGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define RSGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RSGS_ASSERT(lbl, prop, msg)
`define RSGS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/rsgs_pkg.sv */
// Types, sizes and the grade-sum function for the record sorter.
// No dependencies.
package rsgs_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W       = 6;

  // first field in the lowest bits, as on the streams
  typedef struct packed {
    logic [3:0] grade_third;
    logic [3:0] grade_second;
    logic [3:0] grade_first;
    logic [7:0] record_tag;
  } rec_t;

  function automatic logic [SUM_W-1:0] grade_sum(input rec_t r);
    grade_sum = SUM_W'(r.grade_first) + SUM_W'(r.grade_second) + SUM_W'(r.grade_third);
  endfunction

endpackage

/* hw/rtl/record_sort_by_grade_sum_unit.sv */
// Record sorter: loads records, sorts them by grade sum (descending), emits them.
// Depends on rsgs_pkg and assert_macros.svh.
//
// Records arrive one per transfer, one per cycle while the block is loading,
// and are stored in a 16-entry on-chip memory; in_tlast closes the set.
// Records that arrive with the store full are dropped and every result of
// that set then carries out_tuser = 1. After the final record the input
// stalls while the block runs an exchange sort over the n stored records:
// for each i it holds record i in a register and sweeps j over all n
// entries, swapping when sum(i) > sum(j). Each j step is a memory read and a
// compare/write-back, paced by the single read port's registered read data.
// Emission follows in index order: each record is read, then loaded into the
// output register; the next read waits while that result is stalled and
// overlaps its transfer. out_tlast marks the final one.
// Equal sums are never swapped with each other. Input is accepted again as
// soon as the final result sits in the output register; that result drains
// while the next set loads or sorts.
`include "assert_macros.svh"

module record_sort_by_grade_sum_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] record_tag, [11:8] grade_first, [15:12] grade_second,
  // [19:16] grade_third, [23:20] zero
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_tag, [11:8] out_grade_first, [15:12] out_grade_second,
  // [19:16] out_grade_third, [23:20] zero
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // [0] overflowed
  output logic        out_tuser
);

  localparam int IDX_W = rsgs_pkg::IDX_W;
  localparam int CNT_W = rsgs_pkg::CNT_W;

  // sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_RD_I  = 3'd1;
  localparam logic [2:0] ST_LD_I  = 3'd2;
  localparam logic [2:0] ST_RD_J  = 3'd3;
  localparam logic [2:0] ST_CMP_J = 3'd4;
  localparam logic [2:0] ST_WR_I  = 3'd5;
  localparam logic [2:0] ST_EM_RD = 3'd6;
  localparam logic [2:0] ST_EM_LD = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  rsgs_pkg::rec_t   rec_i_r, rec_i_nxt;

  logic             out_valid_r, out_valid_nxt;
  rsgs_pkg::rec_t   out_rec_r, out_rec_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  // record store
  rsgs_pkg::rec_t   mem [rsgs_pkg::MAX_RECORDS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  rsgs_pkg::rec_t   mem_wd;
  logic [IDX_W-1:0] mem_ra;
  rsgs_pkg::rec_t   rd_data_r;

  logic in_xfer, out_xfer;
  logic j_end, i_end;
  logic do_swap;

  assign in_tready = (state_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // step index reaching n-1
  assign j_end = (CNT_W'(j_r) + CNT_W'(1)) == count_r;
  assign i_end = (CNT_W'(i_r) + CNT_W'(1)) == count_r;

  // at j == i the store copy is stale, so that step never swaps
  assign do_swap = (j_r != i_r) &&
                   (rsgs_pkg::grade_sum(rec_i_r) > rsgs_pkg::grade_sum(rd_data_r));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rec_i_nxt     = rec_i_r;
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = count_r[IDX_W-1:0];
    mem_wd        = in_tdata[19:0];
    mem_ra        = i_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (count_r == CNT_W'(rsgs_pkg::MAX_RECORDS)) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        mem_ra    = i_r;
        state_nxt = ST_LD_I;
      end
      ST_LD_I: begin
        rec_i_nxt = rd_data_r;
        j_nxt     = '0;
        state_nxt = ST_RD_J;
      end
      ST_RD_J: begin
        mem_ra    = j_r;
        state_nxt = ST_CMP_J;
      end
      ST_CMP_J: begin
        if (do_swap) begin
          mem_we    = 1'b1;
          mem_wa    = j_r;
          mem_wd    = rec_i_r;
          rec_i_nxt = rd_data_r;
        end
        if (j_end) begin
          state_nxt = ST_WR_I;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_RD_J;
        end
      end
      ST_WR_I: begin
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd = rec_i_r;
        if (i_end) begin
          j_nxt     = '0;  // j now walks the emit order
          state_nxt = ST_EM_RD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_RD_I;
        end
      end
      ST_EM_RD: begin
        // wait here until the previous result has gone
        mem_ra = j_r;
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = rd_data_r;
        out_last_nxt  = j_end;
        out_ovf_nxt   = ovf_r;
        if (j_end) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_EM_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // final result drains while the next set loads or sorts
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rec_i_r    <= rec_i_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_rec_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // store never holds more than its depth
  `RSGS_ASSERT(a_count_bound, count_r <= CNT_W'(rsgs_pkg::MAX_RECORDS), "record count overrun")
  // no input taken while a non-final result is pending
  `RSGS_ASSERT(a_no_load_mid_emit, !(in_tready && out_tvalid && !out_tlast), "load during emission")
  // a stalled result stays offered
  `RSGS_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> out_tvalid, "stalled result lost")

endmodule

/* tb/sorted_record_checker.sv */
// Scoreboard for the record sorter: watches both streams, predicts the sorted output.
// Depends on rsgs_pkg for the record layout and the store size.
`timescale 1ns / 100ps

module sorted_record_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [7:0] record_tag, [11:8] grade_first, [15:12] grade_second,
  // [19:16] grade_third, [23:20] zero
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_tag, [11:8] out_grade_first, [15:12] out_grade_second,
  // [19:16] out_grade_third, [23:20] zero
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  // [0] overflowed
  input  logic        out_tuser,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    rsgs_pkg::rec_t rec;
    logic           last;
    logic           dropped;
  } sorted_entry_t;

  rsgs_pkg::rec_t held_recs [rsgs_pkg::MAX_RECORDS];
  int             held_count = 0;
  logic           dropped_seen = 1'b0;
  int             bad_count = 0;
  sorted_entry_t  due_records [$];

  function automatic logic [5:0] grade_total(input rsgs_pkg::rec_t r);
    return {2'b00, r.grade_first} + {2'b00, r.grade_second} + {2'b00, r.grade_third};
  endfunction

  task automatic note_field(input string field, input int want, input int got);
    if (want != got) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // store one record; on the closing one, sort as the block does and queue the set
  task automatic take_record(input rsgs_pkg::rec_t r, input logic last);
    rsgs_pkg::rec_t swap;
    sorted_entry_t  e;
    int             i, j, k;
    if (held_count < rsgs_pkg::MAX_RECORDS) begin
      held_recs[held_count] = r;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (last) begin
      // full i/j sweep, not a stable sort: ties keep whatever order it leaves
      for (i = 0; i < held_count; i++) begin
        for (j = 0; j < held_count; j++) begin
          if (grade_total(held_recs[i]) > grade_total(held_recs[j])) begin
            swap         = held_recs[i];
            held_recs[i] = held_recs[j];
            held_recs[j] = swap;
          end
        end
      end
      for (k = 0; k < held_count; k++) begin
        e.rec     = held_recs[k];
        e.last    = (k == held_count - 1);
        e.dropped = dropped_seen;
        due_records.push_back(e);
      end
      held_count   = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_entry_t want;
    if (due_records.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: unexpected result, data %h last %b user %b",
                 $time, out_tdata, out_tlast, out_tuser);
    end else begin
      want = due_records.pop_front();
      note_field("tag", want.rec.record_tag, out_tdata[7:0]);
      note_field("grade_first", want.rec.grade_first, out_tdata[11:8]);
      note_field("grade_second", want.rec.grade_second, out_tdata[15:12]);
      note_field("grade_third", want.rec.grade_third, out_tdata[19:16]);
      note_field("padding", 0, out_tdata[23:20]);
      note_field("tlast", want.last, out_tlast);
      note_field("overflow flag", want.dropped, out_tuser);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count   = 0;
      dropped_seen = 1'b0;
      due_records.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) take_record(in_tdata[19:0], in_tlast);
    end
    outstanding <= due_records.size();
    mismatches  <= bad_count;
  end

endmodule

/* tb/tb_record_sort_by_grade_sum_unit.sv */
// Top of the record sorter testbench: clock, reset, stream stimulus and verdict.
// Depends on rsgs_pkg, record_sort_by_grade_sum_unit and sorted_record_checker.
`timescale 1ns / 100ps

module tb_record_sort_by_grade_sum_unit;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [7:0] record_tag, [11:8] grade_first, [15:12] grade_second,
  // [19:16] grade_third, [23:20] zero
  logic [23:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  // [7:0] out_tag, [11:8] out_grade_first, [15:12] out_grade_second,
  // [19:16] out_grade_third, [23:20] zero
  logic [23:0] out_tdata;
  logic        out_tlast;
  // [0] overflowed
  logic        out_tuser;

  int          mismatches;
  int          outstanding;

  // idle rates in percent; sender's is used only by the stimulus process
  int          tx_idle_pct;
  int          rx_idle_pct;
  // asks the receiver for one long hold-off
  logic        hold_armed;

  record_sort_by_grade_sum_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  sorted_record_checker sort_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  // The hold lasts long enough for a sorted set to back up and the input to stall.
  initial begin : receiver
    int   k;
    logic hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_tready <= 1'b0;
        for (k = 0; k < 300; k++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // One record transfer; valid stays high afterwards unless a gap follows.
  task automatic send_record(input logic [7:0] tag, input logic [3:0] g1,
                             input logic [3:0] g2, input logic [3:0] g3,
                             input logic last);
    rsgs_pkg::rec_t r;
    r.record_tag   = tag;
    r.grade_first  = g1;
    r.grade_second = g2;
    r.grade_third  = g3;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, r};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // n random records, the last one closing the set; gmax narrows grades for ties
  task automatic send_set(input int n, input int gmax);
    int k;
    for (k = 0; k < n; k++)
      send_record(8'($urandom_range(0, 255)), 4'($urandom_range(0, gmax)),
                  4'($urandom_range(0, gmax)), 4'($urandom_range(0, gmax)),
                  k == n - 1);
  endtask

  // Sender pause until every predicted result has gone out.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    int n;
    int gmax;
    int sel;
    int sent_random;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    hold_armed  <= 1'b0;
    rx_idle_pct <= 60;
    tx_idle_pct = 23;
    sent_random = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // single-record sets at both ends of every field
    send_record(8'h00, 4'h0, 4'h0, 4'h0, 1'b1);
    send_record(8'hff, 4'hf, 4'hf, 4'hf, 1'b1);
    // several equal sums around a zero and a maximum record
    send_record(8'd1, 4'd3, 4'd3, 4'd3, 1'b0);
    send_record(8'd2, 4'd9, 4'd0, 4'd0, 1'b0);
    send_record(8'd3, 4'd0, 4'd0, 4'd0, 1'b0);
    send_record(8'd4, 4'd15, 4'd15, 4'd15, 1'b0);
    send_record(8'd5, 4'd1, 4'd2, 4'd6, 1'b1);
    // full store, then the closing record arrives with no room and is dropped
    for (k = 0; k < rsgs_pkg::MAX_RECORDS; k++)
      send_record(8'(8'h10 + k), 4'(k), 4'(15 - k), 4'(k / 2), 1'b0);
    send_record(8'haa, 4'd7, 4'd7, 4'd7, 1'b1);
    wait_drained();

    // --- random part ---
    // long receiver hold while the sender keeps offering the first sets
    hold_armed <= 1'b1;
    while (sent_random < 107) begin
      if (sent_random >= 36 && tx_idle_pct == 23) begin
        wait_drained();
        tx_idle_pct = 60;
        rx_idle_pct <= 23;
      end else if (sent_random >= 72 && tx_idle_pct == 60) begin
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // mostly short sets, some near capacity, a few overflowing
      sel = $urandom_range(0, 99);
      if (sel < 75)
        n = $urandom_range(1, 6);
      else if (sel < 92)
        n = $urandom_range(7, rsgs_pkg::MAX_RECORDS);
      else
        n = $urandom_range(rsgs_pkg::MAX_RECORDS + 1, rsgs_pkg::MAX_RECORDS + 4);
      gmax = $urandom_range(0, 1) ? 15 : 3;
      send_set(n, gmax);
      sent_random += n;
    end

    wait_drained();
    // let any stray result show up before the verdict
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rsgs_pkg.sv
hw/rtl/record_sort_by_grade_sum_unit.sv
tb/sorted_record_checker.sv
tb/tb_record_sort_by_grade_sum_unit.sv
